[design/sdr_pkg.sv]
package sdr_pkg;

	localparam int unsigned VALUE_W = 32;

	// Result kinds carried on the output tuser bit
	localparam logic KIND_REPEAT   = 1'b0;
	localparam logic KIND_OVERFLOW = 1'b1;

	// Request payload as it travels down the cell chain
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;    // end of sequence, clear cells behind it
		logic               done;    // matched or stored somewhere upstream
		logic               report;  // first repeat found, emit with KIND_REPEAT
	} item_t;

endpackage

[design/stream_duplicate_reporter.sv]
// Streaming duplicate detector for signed 32-bit values.
// Input channel s_*: one value per request in s_tdata, s_tlast marks the last
// value of a sequence. Output channel m_*: zero or one result per request,
// the value in m_tdata and the kind in m_tuser (0 first repeat of a value,
// 1 store full and value not tracked).
// The store is a chain of CAPACITY cells. Each request walks the chain one
// cell per cycle while the output is not stalled, checking the entry, claiming
// the first empty one, or marking a repeat; the last request of a sequence
// clears every cell it passes. A request passes the register of each cell in
// turn and then the output register before it shows on m_tvalid. A new
// request is accepted every cycle unless a result is stuck at the output; the
// rate is set by the one-cell-per-cycle step of the chain, which holds requests
// at different cells at the same time. Requests that give no result simply
// drop off the end of the chain. Reset empties every cell and the output
// register at once. When the receiver stalls with a result pending, the whole
// chain holds and s_tready drops until the result is taken.
module stream_duplicate_reporter #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [sdr_pkg::VALUE_W-1:0] s_tdata,   // [31:0] value
	input  logic                        s_tlast,   // last_item
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [sdr_pkg::VALUE_W-1:0] m_tdata,   // [31:0] dup_value
	output logic                        m_tuser    // [0] kind
);

	logic                        en;
	logic                        chain_valid [CAPACITY+1];
	sdr_pkg::item_t              chain_item  [CAPACITY+1];
	sdr_pkg::item_t              tail;
	logic                        tail_valid;
	logic                        take;
	logic                        m_tvalid_q;
	logic [sdr_pkg::VALUE_W-1:0] m_tdata_q;
	logic                        m_tuser_q;

	// Advance the chain whenever the output register is free or being drained
	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;

	always_comb begin
		chain_valid[0]       = s_tvalid;
		chain_item[0].value  = s_tdata;
		chain_item[0].last   = s_tlast;
		chain_item[0].done   = 1'b0;
		chain_item[0].report = 1'b0;
	end

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		sdr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_valid[k]),
			.in_item   (chain_item[k]),
			.out_valid (chain_valid[k+1]),
			.out_item  (chain_item[k+1])
		);
	end

	assign tail       = chain_item[CAPACITY];
	assign tail_valid = chain_valid[CAPACITY];

	// Emit a first repeat, or an overflow when no cell took the value
	assign take = tail_valid && (tail.report || !tail.done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (en && take) begin
			m_tdata_q <= tail.value;
			m_tuser_q <= tail.done ? sdr_pkg::KIND_REPEAT : sdr_pkg::KIND_OVERFLOW;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_no_accept_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("request accepted while a result is stuck");

	a_result_from_tail: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(tail_valid))
		else $error("result appeared without a request at the chain end");

	a_chain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(en) |-> $stable(tail_valid))
		else $error("chain moved during an output stall");

endmodule

[design/sdr_cell.sv]
module sdr_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  sdr_pkg::item_t in_item,
	output logic          out_valid,
	output sdr_pkg::item_t out_item
);

	logic [sdr_pkg::VALUE_W-1:0] val_q;
	logic                        vld_q;
	logic                        rep_q;
	logic                        match;
	logic                        claim;
	logic                        step;
	sdr_pkg::item_t              nxt_item;
	sdr_pkg::item_t              item_s1;
	logic                        valid_s1;

	assign step  = en && in_valid;
	assign match = in_valid && !in_item.done && vld_q && (val_q == in_item.value);
	assign claim = in_valid && !in_item.done && !vld_q;

	always_comb begin
		nxt_item        = in_item;
		nxt_item.done   = in_item.done | match | claim;
		nxt_item.report = in_item.report | (match & !rep_q);
	end

	// Entry flags: last request wipes the entry after using it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			rep_q <= 1'b0;
		end else if (step) begin
			if (in_item.last) begin
				vld_q <= 1'b0;
				rep_q <= 1'b0;
			end else if (match) begin
				rep_q <= 1'b1;
			end else if (claim) begin
				vld_q <= 1'b1;
				rep_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && claim) begin
			val_q <= in_item.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= nxt_item;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	a_rep_needs_vld: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q |-> vld_q) else $error("reported mark on an empty entry");

	a_clear_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(vld_q) |-> $past(step && in_item.last))
		else $error("entry dropped without an end of sequence");

	a_value_held: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && $past(vld_q)) |-> $stable(val_q))
		else $error("stored value changed while entry in use");

endmodule
